/* src/ensc_pkg.sv */
// ----------------------------------------------------------------------------
// ensc_pkg: shared types and constants
// Item, result, register and pipeline types of the sensor compensation block.
// ----------------------------------------------------------------------------
package ensc_pkg;

  localparam int PrepStages = 15;
  localparam int DivBits    = 64;
  localparam int PostStages = 5;

  typedef enum logic [2:0] {
    REG_TEMP       = 3'd0,
    REG_PRESS_LOW  = 3'd1,
    REG_PRESS_HIGH = 3'd2,
    REG_PRESS_NINE = 3'd3,
    REG_HUM        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;
    logic [16:0]        humidity_q22_10;
  } result_t;

  typedef struct packed {
    logic [47:0]        temp_coeffs;
    logic [63:0]        press_coeffs_low;
    logic [63:0]        press_coeffs_high;
    logic signed [15:0] press_coeff_nine;
    logic [63:0]        hum_coeffs;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic               neg;
    logic               dz;
  } side_t;

  typedef struct packed {
    logic [DivBits-1:0] nmag;
    logic [DivBits-1:0] dmag;
    side_t              side;
  } div_in_t;

  typedef struct packed {
    logic [DivBits-1:0] qmag;
    side_t              side;
  } div_out_t;

endpackage

/* src/env_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// env_sensor_compensation: temperature, pressure and humidity compensation
// Integer compensation of raw sensor samples against calibration registers.
// ----------------------------------------------------------------------------
// Takes one sample item per clock while the output is not stalled and returns
// one result item per sample, in order, through 84 register stages (15 front
// stages, 64 divider stages, 5 back-end stages). The pressure divider is the
// 64-stage pipelined part. A stalled output freezes the whole pipeline, and
// the sample side stalls with it. Calibration registers must be written only
// while no item is in flight.
module env_sensor_compensation (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  ensc_pkg::sample_t   sample,
  output logic                result_valid,
  input  logic                result_stall,
  output ensc_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  ensc_pkg::cfg_t    cfg;
  ensc_pkg::div_in_t prep_div;
  ensc_pkg::div_out_t div_post;
  logic              adv, prep_valid, div_valid;

  assign adv          = !result_valid || !result_stall;
  assign sample_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ensc_pkg::REG_TEMP:       cfg.temp_coeffs       <= cfg_data[47:0];
        ensc_pkg::REG_PRESS_LOW:  cfg.press_coeffs_low  <= cfg_data;
        ensc_pkg::REG_PRESS_HIGH: cfg.press_coeffs_high <= cfg_data;
        ensc_pkg::REG_PRESS_NINE: cfg.press_coeff_nine  <= $signed(cfg_data[15:0]);
        ensc_pkg::REG_HUM:        cfg.hum_coeffs        <= cfg_data;
        default: ;
      endcase
    end
  end

  ensc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample_valid),
    .sample    (sample),
    .cfg       (cfg),
    .out_valid (prep_valid),
    .out_div   (prep_div)
  );

  ensc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (prep_valid),
    .din       (prep_div),
    .out_valid (div_valid),
    .dout      (div_post)
  );

  ensc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .din       (div_post),
    .cfg       (cfg),
    .out_valid (result_valid),
    .res       (result)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pressure_invalid |-> result.pressure_q24_8 == 32'd0)
    else $error("invalid pressure item carries a nonzero value");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.humidity_q22_10 <= 17'd102400)
    else $error("humidity beyond clamp");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

endmodule

/* src/ensc_prep.sv */
// ----------------------------------------------------------------------------
// ensc_prep: front pipeline
// Temperature and humidity paths in full, pressure path up to the divide.
// ----------------------------------------------------------------------------
module ensc_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  ensc_pkg::sample_t   sample,
  input  ensc_pkg::cfg_t      cfg,
  output logic                out_valid,
  output ensc_pkg::div_in_t   out_div
);

  localparam int Last = ensc_pkg::PrepStages;

  logic [Last:1] vld;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, h2;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;
  logic [7:0]         h1, h3;

  assign t1 = cfg.temp_coeffs[15:0];
  assign t2 = $signed(cfg.temp_coeffs[31:16]);
  assign t3 = $signed(cfg.temp_coeffs[47:32]);
  assign p1 = cfg.press_coeffs_low[15:0];
  assign p2 = $signed(cfg.press_coeffs_low[31:16]);
  assign p3 = $signed(cfg.press_coeffs_low[47:32]);
  assign p4 = $signed(cfg.press_coeffs_low[63:48]);
  assign p5 = $signed(cfg.press_coeffs_high[15:0]);
  assign p6 = $signed(cfg.press_coeffs_high[31:16]);
  assign h1 = cfg.hum_coeffs[7:0];
  assign h2 = $signed(cfg.hum_coeffs[23:8]);
  assign h3 = cfg.hum_coeffs[31:24];
  assign h4 = $signed(cfg.hum_coeffs[43:32]);
  assign h5 = $signed(cfg.hum_coeffs[55:44]);
  assign h6 = $signed(cfg.hum_coeffs[63:56]);

  // temperature
  logic signed [31:0] a1, b1, m1, bb2, v1_3, m2_3, tfine4, x5;
  logic signed [32:0] w1_5;
  logic signed [31:0] temp_d [5:Last];
  logic [19:0]        padc [1:8];
  logic [15:0]        hadc [1:5];

  // pressure
  logic signed [63:0] ww6, w1p5_6, w1p2_6, w2a7, w1a7, w1p5_7, w1p2_7;
  logic signed [63:0] w2_8, w1b8, m9, n9, d10, num10;
  logic [20:0]        pdiff;
  logic [63:0]        nmag_d [11:Last];
  logic [63:0]        dmag_d [11:Last];
  logic               neg_d  [11:Last];
  logic               dz_d   [11:Last];

  // humidity
  logic signed [31:0] hx6, xh6_6, xh3_6, y0_6, y7, za7, zb7, z1_8, y8, z2_9, y9;
  logic signed [31:0] z3_10, y10, z11, y11, xx12, ss13, xx13, t14, xx14;
  logic signed [31:0] s13, hs, hsc;
  logic [16:0]        hum15;

  assign pdiff = 21'd1048576 - {1'b0, padc[8]};
  assign s13   = xx12 >>> 15;

  always_comb begin
    hs = xx14 - (t14 >>> 4);
    if (hs < 0) begin
      hsc = '0;
    end else if (hs > 32'sd419430400) begin
      hsc = 32'sd419430400;
    end else begin
      hsc = hs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Last-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= $signed({15'b0, sample.raw_temperature[19:3]} - {15'b0, t1, 1'b0});
      b1 <= $signed({16'b0, sample.raw_temperature[19:4]} - {16'b0, t1});
      padc[1] <= sample.raw_pressure;
      hadc[1] <= sample.raw_humidity;
      for (int k = 2; k <= 8; k++) padc[k] <= padc[k-1];
      for (int k = 2; k <= 5; k++) hadc[k] <= hadc[k-1];

      m1     <= a1 * 32'(t2);
      bb2    <= b1 * b1;
      v1_3   <= m1 >>> 11;
      m2_3   <= (bb2 >>> 12) * 32'(t3);
      tfine4 <= v1_3 + (m2_3 >>> 14);
      temp_d[5] <= ((tfine4 <<< 2) + tfine4 + 32'sd128) >>> 8;
      for (int k = 6; k <= Last; k++) temp_d[k] <= temp_d[k-1];
      w1_5 <= 33'(tfine4) - 33'sd128000;
      x5   <= tfine4 - 32'sd76800;

      ww6    <= 64'(w1_5) * 64'(w1_5);
      w1p5_6 <= 64'(w1_5) * 64'(p5);
      w1p2_6 <= 64'(w1_5) * 64'(p2);
      w2a7   <= ww6 * 64'(p6);
      w1a7   <= ww6 * 64'(p3);
      w1p5_7 <= w1p5_6;
      w1p2_7 <= w1p2_6;
      w2_8   <= w2a7 + (w1p5_7 <<< 17) + (64'(p4) <<< 35);
      w1b8   <= (w1a7 >>> 8) + (w1p2_7 <<< 12);
      m9     <= (w1b8 + 64'sh0000_8000_0000_0000) * $signed({48'b0, p1});
      n9     <= $signed({12'b0, pdiff, 31'b0}) - w2_8;
      d10    <= m9 >>> 33;
      num10  <= n9 * 64'sd3125;
      nmag_d[11] <= num10[63] ? 64'(-num10) : num10;
      dmag_d[11] <= d10[63] ? 64'(-d10) : d10;
      neg_d[11]  <= num10[63] ^ d10[63];
      dz_d[11]   <= (d10 == 64'sd0);
      for (int k = 12; k <= Last; k++) begin
        nmag_d[k] <= nmag_d[k-1];
        dmag_d[k] <= dmag_d[k-1];
        neg_d[k]  <= neg_d[k-1];
        dz_d[k]   <= dz_d[k-1];
      end

      hx6   <= 32'(h5) * x5;
      xh6_6 <= x5 * 32'(h6);
      xh3_6 <= x5 * $signed({24'b0, h3});
      y0_6  <= $signed({2'b0, hadc[5], 14'b0}) - (32'(h4) <<< 20);
      y7    <= (y0_6 - hx6 + 32'sd16384) >>> 15;
      za7   <= xh6_6 >>> 10;
      zb7   <= (xh3_6 >>> 11) + 32'sd32768;
      z1_8  <= za7 * zb7;
      y8    <= y7;
      z2_9  <= (z1_8 >>> 10) + 32'sd2097152;
      y9    <= y8;
      z3_10 <= z2_9 * 32'(h2);
      y10   <= y9;
      z11   <= (z3_10 + 32'sd8192) >>> 14;
      y11   <= y10;
      xx12  <= y11 * z11;
      ss13  <= s13 * s13;
      xx13  <= xx12;
      t14   <= (ss13 >>> 7) * $signed({24'b0, h1});
      xx14  <= xx13;
      hum15 <= hsc[28:12];
    end
  end

  assign out_valid         = vld[Last];
  assign out_div.nmag      = nmag_d[Last];
  assign out_div.dmag      = dmag_d[Last];
  assign out_div.side.temp = temp_d[Last];
  assign out_div.side.hum  = hum15;
  assign out_div.side.neg  = neg_d[Last];
  assign out_div.side.dz   = dz_d[Last];

endmodule

/* src/ensc_div.sv */
// ----------------------------------------------------------------------------
// ensc_div: pipelined divider
// Unsigned restoring divide of magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ensc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  ensc_pkg::div_in_t   din,
  output logic                out_valid,
  output ensc_pkg::div_out_t  dout
);

  localparam int N = ensc_pkg::DivBits;

  logic [N-1:0]          st_rem  [1:N-1];
  logic [N-1:0]          st_den  [1:N-1];
  logic [N-1:0]          st_num  [1:N];
  ensc_pkg::side_t       st_side [1:N];
  logic [N:1]            st_vld;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [N-1:0]    cur_rem, cur_num, cur_den;
    ensc_pkg::side_t cur_side;
    logic            cur_vld;
    logic [N:0]      trial;
    logic            fits;

    if (i == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_num  = din.nmag;
      assign cur_den  = din.dmag;
      assign cur_side = din.side;
      assign cur_vld  = in_valid;
    end else begin : g_next
      assign cur_rem  = st_rem[i];
      assign cur_num  = st_num[i];
      assign cur_den  = st_den[i];
      assign cur_side = st_side[i];
      assign cur_vld  = st_vld[i];
    end

    assign trial = {cur_rem, cur_num[N-1]};
    assign fits  = trial >= {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[i+1] <= 1'b0;
      end else if (adv) begin
        st_vld[i+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_num[i+1]  <= {cur_num[N-2:0], fits};
        st_side[i+1] <= cur_side;
      end
    end

    if (i < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          st_rem[i+1] <= fits ? N'(trial - {1'b0, cur_den}) : trial[N-1:0];
          st_den[i+1] <= cur_den;
        end
      end
    end
  end

  assign out_valid = st_vld[N];
  assign dout.qmag = st_num[N];
  assign dout.side = st_side[N];

endmodule

/* src/ensc_post.sv */
// ----------------------------------------------------------------------------
// ensc_post: pressure back end
// Signs the quotient, applies the second-order terms and registers the result.
// ----------------------------------------------------------------------------
module ensc_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  ensc_pkg::div_out_t  din,
  input  ensc_pkg::cfg_t      cfg,
  output logic                out_valid,
  output ensc_pkg::result_t   res
);

  localparam int Last = ensc_pkg::PostStages;

  logic [Last:1] vld;

  logic signed [15:0] p7, p8;
  assign p7 = $signed(cfg.press_coeffs_high[47:32]);
  assign p8 = $signed(cfg.press_coeffs_high[63:48]);

  logic signed [63:0] pa, pb, pc, pd, qv, p8p_b, x2_c, x2_d, pq_d, r;
  logic [63:0]        ll_b, qsq_c;
  logic [31:0]        lh_b;
  ensc_pkg::side_t    sa, sb, sc, sd;

  assign qv = pa >>> 13;
  assign r  = ((pd + (pq_d >>> 25) + x2_d) >>> 8) + (64'(p7) <<< 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Last-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa    <= din.side.neg ? $signed(64'(-din.qmag)) : $signed(din.qmag);
      sa    <= din.side;
      ll_b  <= 64'(qv[31:0]) * 64'(qv[31:0]);
      lh_b  <= qv[31:0] * qv[63:32];
      p8p_b <= pa * 64'(p8);
      pb    <= pa;
      sb    <= sa;
      qsq_c <= ll_b + {lh_b[30:0], 1'b0, 32'b0};
      x2_c  <= p8p_b >>> 19;
      pc    <= pb;
      sc    <= sb;
      pq_d  <= $signed(qsq_c) * 64'(cfg.press_coeff_nine);
      x2_d  <= x2_c;
      pd    <= pc;
      sd    <= sc;
      res.temperature_centi <= sd.temp;
      res.pressure_q24_8    <= sd.dz ? 32'd0 : r[31:0];
      res.pressure_invalid  <= sd.dz;
      res.humidity_q22_10   <= sd.hum;
    end
  end

  assign out_valid = vld[Last];

endmodule

/* dv/env_sensor_compensation_tb.sv */
// ----------------------------------------------------------------------------
// env_sensor_compensation_tb: self-checking testbench
// Drives raw sensor items under several calibration settings, predicts the
// compensated temperature, pressure and humidity of each accepted item and
// compares every result item in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module env_sensor_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 84;
  localparam longint CycleLimit = 400000;

  logic                clk;
  logic                rst;
  logic                sample_valid;
  logic                sample_stall;
  ensc_pkg::sample_t   sample;
  logic                result_valid;
  logic                result_stall;
  ensc_pkg::result_t   result;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [63:0]         cfg_data;

  env_sensor_compensation i_dut (
    .clk, .rst, .sample_valid, .sample_stall, .sample, .result_valid,
    .result_stall, .result, .cfg_we, .cfg_index, .cfg_data
  );

  ensc_pkg::cfg_t    cal;
  ensc_pkg::sample_t pending_q[$];
  ensc_pkg::result_t expected_q[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_len = 0;
  int      hold_off;
  bit      hold_used;
  bit      failed = 1'b0;
  longint  cycles = 0;

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic ensc_pkg::result_t compensate(ensc_pkg::sample_t s);
    ensc_pkg::result_t r;
    logic [31:0] t1, t2, t3, a, b, v1, v2, tfine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q, x1, x2;
    logic [63:0] nm, dm, qm;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, y, z, sq;
    logic signed [31:0] hs;
    logic [31:0] adc_t, adc_h;
    adc_t = {12'd0, s.raw_temperature};
    adc_h = {16'd0, s.raw_humidity};
    t1 = {16'd0, cal.temp_coeffs[15:0]};
    t2 = {{16{cal.temp_coeffs[31]}}, cal.temp_coeffs[31:16]};
    t3 = {{16{cal.temp_coeffs[47]}}, cal.temp_coeffs[47:32]};
    a = sra32(adc_t, 3) - (t1 << 1);
    v1 = sra32(a * t2, 11);
    b = sra32(adc_t, 4) - t1;
    v2 = sra32(sra32(b * b, 12) * t3, 14);
    tfine = v1 + v2;
    r.temperature_centi = sra32(tfine * 32'd5 + 32'd128, 8);

    p1 = {48'd0, cal.press_coeffs_low[15:0]};
    p2 = {{48{cal.press_coeffs_low[31]}}, cal.press_coeffs_low[31:16]};
    p3 = {{48{cal.press_coeffs_low[47]}}, cal.press_coeffs_low[47:32]};
    p4 = {{48{cal.press_coeffs_low[63]}}, cal.press_coeffs_low[63:48]};
    p5 = {{48{cal.press_coeffs_high[15]}}, cal.press_coeffs_high[15:0]};
    p6 = {{48{cal.press_coeffs_high[31]}}, cal.press_coeffs_high[31:16]};
    p7 = {{48{cal.press_coeffs_high[47]}}, cal.press_coeffs_high[47:32]};
    p8 = {{48{cal.press_coeffs_high[63]}}, cal.press_coeffs_high[63:48]};
    p9 = {{48{cal.press_coeff_nine[15]}}, cal.press_coeff_nine};
    w1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
    r.pressure_q24_8 = '0;
    r.pressure_invalid = 1'b0;
    if (w1 == 0) begin
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, s.raw_pressure};
      p = ((p << 31) - w2) * 64'd3125;
      nm = p[63] ? -p : p;
      dm = w1[63] ? -w1 : w1;
      qm = nm / dm;
      p = (p[63] != w1[63]) ? -qm : qm;
      q = sra64(p, 13);
      x1 = sra64(p9 * q * q, 25);
      x2 = sra64(p8 * p, 19);
      p = sra64(p + x1 + x2, 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
    end

    h1 = {24'd0, cal.hum_coeffs[7:0]};
    h2 = {{16{cal.hum_coeffs[23]}}, cal.hum_coeffs[23:8]};
    h3 = {24'd0, cal.hum_coeffs[31:24]};
    h4 = {{20{cal.hum_coeffs[43]}}, cal.hum_coeffs[43:32]};
    h5 = {{20{cal.hum_coeffs[55]}}, cal.hum_coeffs[55:44]};
    h6 = {{24{cal.hum_coeffs[63]}}, cal.hum_coeffs[63:56]};
    x = tfine - 32'd76800;
    y = (adc_h << 14) - (h4 << 20) - h5 * x;
    y = sra32(y + 32'd16384, 15);
    z = sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768);
    z = sra32(z, 10) + 32'd2097152;
    z = sra32(z * h2 + 32'd8192, 14);
    x = y * z;
    sq = sra32(x, 15);
    x = x - sra32(sra32(sq * sq, 7) * h1, 4);
    hs = x;
    if (hs < 0) hs = 0;
    if (hs > 419430400) hs = 419430400;
    r.humidity_q22_10 = hs[28:12];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      sample <= '0;
    end else if (!(sample_valid && sample_stall)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_valid <= 1'b1;
        sample <= pending_q[0];
        expected_q.push_back(compensate(pending_q[0]));
        void'(pending_q.pop_front());
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off once requested
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_off <= 0;
      hold_used <= 1'b0;
    end else if (hold_off > 0) begin
      result_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (!hold_used && hold_len > 0 && result_valid) begin
      result_stall <= 1'b1;
      hold_off <= hold_len;
      hold_used <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, result);
        failed <= 1'b1;
      end else begin
        if (result !== expected_q[0]) begin
          $display("%0t: mismatch expected t=%0d p=%h inv=%b h=%0d",
                   $time, expected_q[0].temperature_centi,
                   expected_q[0].pressure_q24_8, expected_q[0].pressure_invalid,
                   expected_q[0].humidity_q22_10);
          $display("%0t:          actual   t=%0d p=%h inv=%b h=%0d",
                   $time, result.temperature_centi, result.pressure_q24_8,
                   result.pressure_invalid, result.humidity_q22_10);
          failed <= 1'b1;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // the caller drops the write enable after the last write
  task automatic write_reg(ensc_pkg::cfg_reg_t idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      ensc_pkg::REG_TEMP:       cal.temp_coeffs = data[47:0];
      ensc_pkg::REG_PRESS_LOW:  cal.press_coeffs_low = data;
      ensc_pkg::REG_PRESS_HIGH: cal.press_coeffs_high = data;
      ensc_pkg::REG_PRESS_NINE: cal.press_coeff_nine = data[15:0];
      ensc_pkg::REG_HUM:        cal.hum_coeffs = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || sample_valid)
      @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic load_cal(int kind);
    case (kind)
      0: begin
        // typical factory calibration
        write_reg(ensc_pkg::REG_TEMP, {16'd0, 16'd50, 16'd26435, 16'd27504});
        write_reg(ensc_pkg::REG_PRESS_LOW, {16'd2855, 16'd3024, 16'hd4bd, 16'd36477});
        write_reg(ensc_pkg::REG_PRESS_HIGH, {16'hfff9, 16'd15500, 16'hfff9, 16'd140});
        write_reg(ensc_pkg::REG_PRESS_NINE, 64'd6000);
        write_reg(ensc_pkg::REG_HUM, {8'd30, 12'd50, 12'd312, 8'd0, 16'd360, 8'd75});
      end
      1: begin
        write_reg(ensc_pkg::REG_TEMP, 64'hffff_ffff_ffff);
        write_reg(ensc_pkg::REG_PRESS_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(ensc_pkg::REG_PRESS_HIGH, 64'hffff_ffff_ffff_ffff);
        write_reg(ensc_pkg::REG_PRESS_NINE, 64'hffff);
        write_reg(ensc_pkg::REG_HUM, 64'hffff_ffff_ffff_ffff);
      end
      2: begin
        write_reg(ensc_pkg::REG_TEMP, 64'h8000_8000_0000);
        write_reg(ensc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_0000);
        write_reg(ensc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
        write_reg(ensc_pkg::REG_PRESS_NINE, 64'h8000);
        write_reg(ensc_pkg::REG_HUM, 64'h8008_0080_0080_0000);
      end
      3: begin
        write_reg(ensc_pkg::REG_TEMP, 64'h7fff_7fff_ffff);
        write_reg(ensc_pkg::REG_PRESS_LOW, 64'h7fff_7fff_7fff_ffff);
        write_reg(ensc_pkg::REG_PRESS_HIGH, 64'h7fff_7fff_7fff_7fff);
        write_reg(ensc_pkg::REG_PRESS_NINE, 64'h7fff);
        write_reg(ensc_pkg::REG_HUM, 64'h7f7f_f7ff_ff7f_ffff);
      end
      default: begin
        write_reg(ensc_pkg::REG_TEMP, {$urandom, $urandom});
        write_reg(ensc_pkg::REG_PRESS_LOW, {$urandom, $urandom});
        write_reg(ensc_pkg::REG_PRESS_HIGH, {$urandom, $urandom});
        write_reg(ensc_pkg::REG_PRESS_NINE, {$urandom, $urandom});
        write_reg(ensc_pkg::REG_HUM, {$urandom, $urandom});
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int n);
    ensc_pkg::sample_t s;
    repeat (n) begin
      s.raw_temperature = 20'($urandom);
      s.raw_pressure = 20'($urandom);
      s.raw_humidity = 16'($urandom);
      if ($urandom_range(3) != 0) begin
        // plausible readings around room conditions
        s.raw_temperature = 20'd500000 + 20'($urandom_range(100000));
        s.raw_pressure = 20'd300000 + 20'($urandom_range(150000));
        s.raw_humidity = 16'd20000 + 16'($urandom_range(30000));
      end
      pending_q.push_back(s);
    end
  endtask

  initial begin
    ensc_pkg::sample_t s;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration: zero pressure divisor
    pending_q.push_back('0);
    pending_q.push_back('1);
    drain();

    // directed extremes under each fixed calibration
    for (int k = 0; k < 4; k++) begin
      load_cal(k);
      s = '0;               pending_q.push_back(s);
      s = '1;               pending_q.push_back(s);
      s = {20'hfffff, 20'd0, 16'hffff}; pending_q.push_back(s);
      s = {20'd0, 20'hfffff, 16'd0};    pending_q.push_back(s);
      s = {20'd519888, 20'd415148, 16'd30000}; pending_q.push_back(s);
      drain();
    end

    // random phases with the three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 24 : 0;
      load_cal(ph == 2 ? 0 : 4);
      if (ph == 2) hold_len = 300;
      queue_random(200);
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_cal(5);
    queue_random(80);
    drain();

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
